FILE: sv/rild_pkg.sv
// Shared types, constants and helpers for the interference level derive unit.
// Used by rild_front, rild_queue, rild_back and the top level; no dependencies.
package rild_pkg;

	localparam logic [12:0] ONE_Q12      = 13'd4096;
	localparam logic [12:0] RF_FLOOR_Q12 = 13'd1434;
	localparam logic [12:0] IF_FLOOR_Q12 = 13'd819;
	// cv at or above this gives avcT = 1.0 (5120 / 1.25 = 4096)
	localparam logic [14:0] AVC_SAT_CV   = 15'd5120;
	// floor(x / 5) = (x * 52429) >> 18, exact for x < 2^18
	localparam logic [31:0] RECIP5       = 32'd52429;

	localparam int DIV_STEPS = 13;
	localparam int NSTAGE    = 18;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;

	typedef enum logic [2:0] {
		REG_IF_NOISE_BASE   = 3'd0,
		REG_POST_NOISE_AMP  = 3'd1,
		REG_CRACKLE_AMP     = 3'd2,
		REG_CRACKLE_RATE    = 3'd3,
		REG_HUM_LEVEL       = 3'd4,
		REG_RF_AVC_DEPTH    = 3'd5,
		REG_IF_AVC_DEPTH    = 3'd6,
		REG_CRACKLE_AT_DET  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] if_noise_base;
		logic [15:0] post_noise_amp;
		logic [15:0] crackle_amp_base;
		logic [15:0] crackle_rate_base;
		logic [15:0] hum_level;
		logic [15:0] rf_avc_depth;
		logic [15:0] if_avc_depth;
		logic        crackle_at_detector;
	} cfg_t;

	// classified item as it sits in the queue
	typedef struct packed {
		logic [12:0] avc_t;
		logic [12:0] carr;
		logic [12:0] lock;
		logic        given;
		logic [12:0] mis_g;
		logic        ovf;
		logic [23:0] off_abs;
		logic [23:0] bw;
	} item_t;

	typedef struct packed {
		logic [12:0] avc_t;
		logic [12:0] carr;
		logic [12:0] lock;
		logic        given;
		logic [12:0] mis_g;
		logic        ovf;
		logic [23:0] rem;
		logic [23:0] bw;
		logic [12:0] quo;
		logic [28:0] rf_p;
		logic [28:0] if_p;
		logic [12:0] rf_g;
		logic [12:0] if_g;
		logic [12:0] pre_g;
		logic [15:0] nb;
		logic [15:0] ca_g;
		logic [12:0] t1;
		logic [12:0] expo;
		logic [12:0] esq;
		logic [15:0] rate;
		logic [15:0] det_amp;
		logic [15:0] post_amp;
	} bk_t;

	typedef struct packed {
		logic [15:0] detector_noise_amp;
		logic [15:0] detector_crackle_amp;
		logic [15:0] detector_crackle_rate;
		logic [15:0] post_crackle_amp;
		logic [15:0] post_crackle_rate;
		logic [15:0] noise_amp;
		logic [15:0] hum_amp;
		logic        hum_enabled;
	} res_t;

	// |v| clamped to 1.0 in Q12; handles the most negative code
	function automatic logic [12:0] mag_clamp(input logic [15:0] v);
		logic [16:0] ext;
		logic [16:0] a;
		begin
			ext = {v[15], v};
			a = v[15] ? (17'd0 - ext) : ext;
			mag_clamp = (a > 17'(ONE_Q12)) ? ONE_Q12 : a[12:0];
		end
	endfunction

endpackage

FILE: sv/rild_front.sv
// Front end: accepts a sample and classifies it into a queue item.
// Depends on rild_pkg.
module rild_front (
	input  logic                 push,
	input  logic                 q_full,
	input  logic signed [15:0]   control_voltage,
	input  logic                 mistune_given,
	input  logic signed [15:0]   mistune_norm,
	input  logic [23:0]          tuned_bandwidth_hz,
	input  logic signed [23:0]   tune_offset_hz,
	input  logic signed [15:0]   tuning_error,
	output logic                 q_wr,
	output rild_pkg::item_t      q_item
);

	logic        cv_pos;
	logic [14:0] cv_u;
	logic [14:0] x4;
	logic [31:0] p5;
	logic [24:0] off_ext;
	logic [24:0] off_a;
	logic [23:0] bwf;

	assign q_wr = push && !q_full;

	always_comb begin
		cv_pos = !control_voltage[15] && (control_voltage != 16'sd0);
		cv_u   = control_voltage[14:0];
		x4     = {cv_u[12:0], 2'b00};
		p5     = 32'(x4) * rild_pkg::RECIP5;

		q_item.avc_t = 13'd0;
		q_item.carr  = 13'd0;
		if (cv_pos) begin
			q_item.avc_t = (cv_u >= rild_pkg::AVC_SAT_CV) ? rild_pkg::ONE_Q12 : p5[30:18];
			q_item.carr  = (cv_u > 15'(rild_pkg::ONE_Q12)) ? rild_pkg::ONE_Q12 : cv_u[12:0];
		end
		q_item.lock  = rild_pkg::ONE_Q12 - rild_pkg::mag_clamp(tuning_error);
		q_item.given = mistune_given;
		q_item.mis_g = rild_pkg::mag_clamp(mistune_norm);

		off_ext = {tune_offset_hz[23], tune_offset_hz};
		off_a   = tune_offset_hz[23] ? (25'd0 - off_ext) : off_ext;
		bwf     = (tuned_bandwidth_hz == 24'd0) ? 24'd1 : tuned_bandwidth_hz;
		q_item.off_abs = off_a[23:0];
		q_item.bw      = bwf;
		// quotient would be 2.0 or more: mistune clamps to 1.0
		q_item.ovf     = (off_a[23:0] >= bwf);
	end

endmodule

FILE: sv/rild_queue.sv
// Short queue of classified items between front and back end.
// Depends on rild_pkg.
module rild_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  rild_pkg::item_t   wr_item,
	output logic              full,
	input  logic              rd,
	output rild_pkg::item_t   rd_item,
	output logic              q_empty
);

	rild_pkg::item_t                 mem_q [rild_pkg::QDEPTH];
	logic [rild_pkg::QPTR_W-1:0]     wptr_q;
	logic [rild_pkg::QPTR_W-1:0]     rptr_q;
	logic [rild_pkg::QPTR_W:0]       cnt_q;

	assign full    = (cnt_q == (rild_pkg::QPTR_W+1)'(rild_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wr_item;
	end

endmodule

FILE: sv/rild_back.sv
// Back end: gain, mistune divider and crackle exposure pipeline plus result buffer.
// Depends on rild_pkg.
module rild_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rild_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  rild_pkg::item_t   q_item,
	output logic              q_rd,
	output logic              empty,
	input  logic              pop,
	output rild_pkg::res_t    res
);

	rild_pkg::bk_t   stage_s [rild_pkg::NSTAGE];
	logic            vld_s   [rild_pkg::NSTAGE];
	rild_pkg::bk_t   nxt     [rild_pkg::NSTAGE];
	rild_pkg::res_t  ob_q    [2];
	rild_pkg::res_t  ob_in;
	logic            ob_wptr_q;
	logic            ob_rptr_q;
	logic [1:0]      ob_cnt_q;
	logic            ob_full;
	logic            adv;
	logic            ob_wr;
	logic            ob_rd;
	logic [24:0]     r2;
	logic [16:0]     red;
	logic [25:0]     m26;
	logic [28:0]     m29;
	logic [12:0]     mis;

	assign ob_full = (ob_cnt_q == 2'd2);
	assign adv     = !(vld_s[rild_pkg::NSTAGE-1] && ob_full);
	assign q_rd    = adv && !q_empty;
	assign ob_wr   = adv && vld_s[rild_pkg::NSTAGE-1];
	assign ob_rd   = pop && !empty;
	assign empty   = (ob_cnt_q == 2'd0);
	assign res     = ob_q[ob_rptr_q];

	always_comb begin
		nxt[0]         = '0;
		nxt[0].avc_t   = q_item.avc_t;
		nxt[0].carr    = q_item.carr;
		nxt[0].lock    = q_item.lock;
		nxt[0].given   = q_item.given;
		nxt[0].mis_g   = q_item.mis_g;
		nxt[0].ovf     = q_item.ovf;
		nxt[0].rem     = q_item.off_abs;
		nxt[0].bw      = q_item.bw;
		r2  = '0;
		red = '0;
		m26 = '0;
		m29 = '0;
		mis = '0;
		for (int k = 1; k < rild_pkg::NSTAGE; k++) begin
			nxt[k] = stage_s[k-1];
			// restoring division, one quotient bit per stage
			if (k <= rild_pkg::DIV_STEPS) begin
				r2 = {stage_s[k-1].rem, 1'b0};
				if (r2 >= {1'b0, stage_s[k-1].bw}) begin
					r2 = r2 - {1'b0, stage_s[k-1].bw};
					nxt[k].quo = {stage_s[k-1].quo[11:0], 1'b1};
				end else begin
					nxt[k].quo = {stage_s[k-1].quo[11:0], 1'b0};
				end
				nxt[k].rem = r2[23:0];
			end
			if (k == 1) begin
				nxt[k].rf_p = 29'(cfg.rf_avc_depth) * 29'(stage_s[k-1].avc_t);
				nxt[k].if_p = 29'(cfg.if_avc_depth) * 29'(stage_s[k-1].avc_t);
			end
			if (k == 2) begin
				red = stage_s[k-1].rf_p[28:12];
				nxt[k].rf_g = (red > 17'(rild_pkg::ONE_Q12 - rild_pkg::RF_FLOOR_Q12)) ?
					rild_pkg::RF_FLOOR_Q12 : 13'(17'(rild_pkg::ONE_Q12) - red);
				red = stage_s[k-1].if_p[28:12];
				nxt[k].if_g = (red > 17'(rild_pkg::ONE_Q12 - rild_pkg::IF_FLOOR_Q12)) ?
					rild_pkg::IF_FLOOR_Q12 : 13'(17'(rild_pkg::ONE_Q12) - red);
			end
			if (k == 3) begin
				m26 = 26'(stage_s[k-1].rf_g) * 26'(stage_s[k-1].if_g);
				nxt[k].pre_g = m26[24:12];
			end
			// products below never exceed full scale: one factor is at most 1.0
			if (k == 4) begin
				m29 = 29'(cfg.if_noise_base) * 29'(stage_s[k-1].pre_g);
				nxt[k].nb = m29[27:12];
				m29 = 29'(cfg.crackle_amp_base) * 29'(stage_s[k-1].pre_g);
				nxt[k].ca_g = m29[27:12];
			end
			if (k == rild_pkg::DIV_STEPS + 1) begin
				if (stage_s[k-1].given) mis = stage_s[k-1].mis_g;
				else if (stage_s[k-1].ovf || stage_s[k-1].quo > rild_pkg::ONE_Q12)
					mis = rild_pkg::ONE_Q12;
				else mis = stage_s[k-1].quo;
				m26 = 26'(stage_s[k-1].carr) * 26'(rild_pkg::ONE_Q12 - mis);
				nxt[k].t1 = m26[24:12];
			end
			if (k == rild_pkg::DIV_STEPS + 2) begin
				m26 = 26'(stage_s[k-1].t1) * 26'(stage_s[k-1].lock);
				nxt[k].expo = rild_pkg::ONE_Q12 - m26[24:12];
			end
			if (k == rild_pkg::DIV_STEPS + 3) begin
				m26 = 26'(stage_s[k-1].expo) * 26'(stage_s[k-1].expo);
				nxt[k].esq = m26[24:12];
				m29 = 29'(cfg.crackle_rate_base) * 29'(stage_s[k-1].expo);
				nxt[k].rate = m29[27:12];
			end
			if (k == rild_pkg::DIV_STEPS + 4) begin
				m29 = 29'(stage_s[k-1].ca_g) * 29'(stage_s[k-1].esq);
				nxt[k].det_amp = m29[27:12];
				m29 = 29'(cfg.crackle_amp_base) * 29'(stage_s[k-1].esq);
				nxt[k].post_amp = m29[27:12];
			end
		end
	end

	always_comb begin
		ob_in = '0;
		ob_in.detector_noise_amp = stage_s[rild_pkg::NSTAGE-1].nb;
		if (cfg.crackle_at_detector) begin
			ob_in.detector_crackle_amp  = stage_s[rild_pkg::NSTAGE-1].det_amp;
			ob_in.detector_crackle_rate = stage_s[rild_pkg::NSTAGE-1].rate;
		end else begin
			ob_in.post_crackle_amp  = stage_s[rild_pkg::NSTAGE-1].post_amp;
			ob_in.post_crackle_rate = stage_s[rild_pkg::NSTAGE-1].rate;
		end
		ob_in.noise_amp   = cfg.post_noise_amp;
		ob_in.hum_amp     = cfg.hum_level;
		ob_in.hum_enabled = (cfg.hum_level != 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < rild_pkg::NSTAGE; k++) vld_s[k] <= 1'b0;
			ob_wptr_q <= 1'b0;
			ob_rptr_q <= 1'b0;
			ob_cnt_q  <= 2'd0;
		end else begin
			if (adv) begin
				vld_s[0] <= !q_empty;
				for (int k = 1; k < rild_pkg::NSTAGE; k++) vld_s[k] <= vld_s[k-1];
			end
			if (ob_wr) ob_wptr_q <= !ob_wptr_q;
			if (ob_rd) ob_rptr_q <= !ob_rptr_q;
			if (ob_wr && !ob_rd) ob_cnt_q <= ob_cnt_q + 2'd1;
			else if (ob_rd && !ob_wr) ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < rild_pkg::NSTAGE; k++) stage_s[k] <= nxt[k];
		end
		if (ob_wr) ob_q[ob_wptr_q] <= ob_in;
	end

endmodule

FILE: sv/radio_interference_level_derive_unit.sv
// Top level of the radio interference level derive unit: config registers,
// front end, item queue and back end. Depends on rild_pkg, rild_front, rild_queue, rild_back.
//
// channel   direction  handshake               beat
// input     in         push / full             one sample: cv, mistune, bw, offset, error
// result    out        empty / pop             noise, crackle and hum levels
// config    in         cfg_we, cfg_index       one 16-bit register write
//
// One sample per cycle sustained while results are popped; each sample passes through the
// queue, the 18-stage back end (sized by the 13-step mistune divider) and the result buffer.
// Reset clears the registers, the queue and all valid bits; no clearing pass.
// A full result buffer stalls the back end; the 4-entry queue then fills before full rises.
module radio_interference_level_derive_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                push,
	output logic                full,
	input  logic signed [15:0]  control_voltage,
	input  logic                mistune_given,
	input  logic signed [15:0]  mistune_norm,
	input  logic [23:0]         tuned_bandwidth_hz,
	input  logic signed [23:0]  tune_offset_hz,
	input  logic signed [15:0]  tuning_error,
	output logic                empty,
	input  logic                pop,
	output logic [15:0]         detector_noise_amp,
	output logic [15:0]         detector_crackle_amp,
	output logic [15:0]         detector_crackle_rate,
	output logic [15:0]         post_crackle_amp,
	output logic [15:0]         post_crackle_rate,
	output logic [15:0]         noise_amp,
	output logic [15:0]         hum_amp,
	output logic                hum_enabled
);

	rild_pkg::cfg_t   cfg_q;
	rild_pkg::item_t  fe_item;
	rild_pkg::item_t  q_item;
	rild_pkg::res_t   res;
	logic             q_wr;
	logic             q_rd;
	logic             q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (rild_pkg::reg_idx_t'(cfg_index))
				rild_pkg::REG_IF_NOISE_BASE:  cfg_q.if_noise_base       <= cfg_data;
				rild_pkg::REG_POST_NOISE_AMP: cfg_q.post_noise_amp      <= cfg_data;
				rild_pkg::REG_CRACKLE_AMP:    cfg_q.crackle_amp_base    <= cfg_data;
				rild_pkg::REG_CRACKLE_RATE:   cfg_q.crackle_rate_base   <= cfg_data;
				rild_pkg::REG_HUM_LEVEL:      cfg_q.hum_level           <= cfg_data;
				rild_pkg::REG_RF_AVC_DEPTH:   cfg_q.rf_avc_depth        <= cfg_data;
				rild_pkg::REG_IF_AVC_DEPTH:   cfg_q.if_avc_depth        <= cfg_data;
				rild_pkg::REG_CRACKLE_AT_DET: cfg_q.crackle_at_detector <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rild_front u_front (
		.push               (push),
		.q_full             (full),
		.control_voltage    (control_voltage),
		.mistune_given      (mistune_given),
		.mistune_norm       (mistune_norm),
		.tuned_bandwidth_hz (tuned_bandwidth_hz),
		.tune_offset_hz     (tune_offset_hz),
		.tuning_error       (tuning_error),
		.q_wr               (q_wr),
		.q_item             (fe_item)
	);

	rild_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (fe_item),
		.full    (full),
		.rd      (q_rd),
		.rd_item (q_item),
		.q_empty (q_empty)
	);

	rild_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_item  (q_item),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign detector_noise_amp    = res.detector_noise_amp;
	assign detector_crackle_amp  = res.detector_crackle_amp;
	assign detector_crackle_rate = res.detector_crackle_rate;
	assign post_crackle_amp      = res.post_crackle_amp;
	assign post_crackle_rate     = res.post_crackle_rate;
	assign noise_amp             = res.noise_amp;
	assign hum_amp               = res.hum_amp;
	assign hum_enabled           = res.hum_enabled;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for radio_interference_level_derive_unit.
// Random and directed samples against an in-bench level predictor; depends on rild_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] cv;
		logic        given;
		logic [15:0] norm;
		logic [23:0] bw;
		logic [23:0] off;
		logic [15:0] err;
	} sample_t;

	typedef struct packed {
		logic [15:0] det_noise, det_camp, det_crate, post_camp, post_crate, noise, hum;
		logic        hum_on;
	} levels_t;

	class level_board;
		logic [15:0] regs [8];
		levels_t     pending [$];
		int          mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			mismatches = 0;
		endfunction

		function void write_reg(rild_pkg::reg_idx_t idx, logic [15:0] val);
			regs[idx] = (idx == rild_pkg::REG_CRACKLE_AT_DET) ? {15'd0, val[0]} : val;
		endfunction

		function longint unsigned clamp_one(longint v);
			longint unsigned a;
			a = (v < 0) ? -v : v;
			return (a > 4096) ? 4096 : a;
		endfunction

		function longint unsigned gain(longint unsigned depth, longint unsigned avc,
				longint unsigned flr);
			longint unsigned red;
			red = (depth * avc) >> 12;
			if (red >= 4096 || 4096 - red < flr) return flr;
			return 4096 - red;
		endfunction

		function longint unsigned sat(longint unsigned v);
			return (v > 65535) ? 65535 : v;
		endfunction

		function void note_sample(sample_t s);
			longint cv, off;
			longint unsigned avc, g, mis, a, b, lock, carr, ex, esq, rate;
			levels_t r;
			cv = longint'($signed(s.cv));
			off = longint'($signed(s.off));
			avc = 0;
			if (cv > 0) begin
				avc = (cv * 4) / 5;
				if (avc > 4096) avc = 4096;
			end
			g = (gain(regs[rild_pkg::REG_RF_AVC_DEPTH], avc, 1434)
				* gain(regs[rild_pkg::REG_IF_AVC_DEPTH], avc, 819)) >> 12;
			if (s.given) mis = clamp_one(longint'($signed(s.norm)));
			else begin
				a = (off < 0) ? -off : off;
				b = (s.bw == 0) ? 1 : s.bw;
				mis = (a * 2 * 4096) / b;
				if (mis > 4096) mis = 4096;
			end
			lock = 4096 - clamp_one(longint'($signed(s.err)));
			carr = (cv <= 0) ? 0 : ((cv > 4096) ? 4096 : cv);
			ex = 4096 - ((((carr * (4096 - mis)) >> 12) * lock) >> 12);
			esq = (ex * ex) >> 12;
			rate = sat((regs[rild_pkg::REG_CRACKLE_RATE] * ex) >> 12);
			r.det_noise = 16'(sat((regs[rild_pkg::REG_IF_NOISE_BASE] * g) >> 12));
			if (regs[rild_pkg::REG_CRACKLE_AT_DET][0]) begin
				r.det_camp = 16'(sat((((regs[rild_pkg::REG_CRACKLE_AMP] * g) >> 12)
					* esq) >> 12));
				r.det_crate = 16'(rate);
				r.post_camp = '0;
				r.post_crate = '0;
			end else begin
				r.det_camp = '0;
				r.det_crate = '0;
				r.post_camp = 16'(sat((regs[rild_pkg::REG_CRACKLE_AMP] * esq) >> 12));
				r.post_crate = 16'(rate);
			end
			r.noise = regs[rild_pkg::REG_POST_NOISE_AMP];
			r.hum = regs[rild_pkg::REG_HUM_LEVEL];
			r.hum_on = (regs[rild_pkg::REG_HUM_LEVEL] != 16'd0);
			pending.push_back(r);
		endfunction

		function void check_levels(levels_t got);
			levels_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat");
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %h %h %h %h %h %h %h %b got %h %h %h %h %h %h %h %b",
						e.det_noise, e.det_camp, e.det_crate, e.post_camp, e.post_crate,
						e.noise, e.hum, e.hum_on, got.det_noise, got.det_camp,
						got.det_crate, got.post_camp, got.post_crate, got.noise,
						got.hum, got.hum_on);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0, push = 0, pop = 0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic full, empty;
	logic signed [15:0] control_voltage = '0, mistune_norm = '0, tuning_error = '0;
	logic mistune_given = 0;
	logic [23:0] tuned_bandwidth_hz = '0;
	logic signed [23:0] tune_offset_hz = '0;
	logic [15:0] detector_noise_amp, detector_crackle_amp, detector_crackle_rate;
	logic [15:0] post_crackle_amp, post_crackle_rate, noise_amp, hum_amp;
	logic hum_enabled;

	level_board board = new();
	bit quiet = 0;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	radio_interference_level_derive_unit u_dut (.*);

	// result side: random pop bursts, check on each accepted beat
	int pop_hold = 0;
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_levels('{detector_noise_amp, detector_crackle_amp,
				detector_crackle_rate, post_crackle_amp, post_crackle_rate,
				noise_amp, hum_amp, hum_enabled});
		if (quiet) pop <= 1;
		else if (pop_hold > 0) begin
			pop_hold--;
			pop <= 0;
		end else if ($urandom_range(0, 7) == 0) begin
			pop_hold = $urandom_range(0, 11);
			pop <= 0;
		end else pop <= 1;
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(rild_pkg::reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		board.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic send(sample_t s);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		control_voltage <= s.cv;
		mistune_given <= s.given;
		mistune_norm <= s.norm;
		tuned_bandwidth_hz <= s.bw;
		tune_offset_hz <= s.off;
		tuning_error <= s.err;
		do @(posedge clk); while (full);
		board.note_sample(s);
	endtask

	task automatic idle_input();
		push <= 0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h1000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s.cv = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6000));
		s.given = 1'($urandom());
		s.norm = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($signed($urandom_range(0, 8192)) - 4096);
		s.bw = ($urandom_range(0, 2) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 20000));
		s.off = ($urandom_range(0, 2) == 0) ? 24'($urandom()) : 24'($signed($urandom_range(0, 20000)) - 10000);
		s.err = ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'($signed($urandom_range(0, 8192)) - 4096);
		return s;
	endfunction

	task automatic random_regs();
		for (int i = 0; i < 8; i++) write_reg(rild_pkg::reg_idx_t'(i), pick16());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: full-scale bases, detector routing
		for (int i = 0; i < 7; i++) write_reg(rild_pkg::reg_idx_t'(i), 16'hffff);
		write_reg(rild_pkg::REG_CRACKLE_AT_DET, 16'd1);
		send('{16'h8000, 1'b1, 16'h8000, 24'd0, 24'h800000, 16'h8000});
		send('{16'h7fff, 1'b1, 16'h7fff, 24'hffffff, 24'h7fffff, 16'h7fff});
		send('{16'h0000, 1'b0, 16'h0000, 24'd0, 24'd5, 16'h0000});
		send('{16'h1000, 1'b0, 16'h0000, 24'd10000, 24'hfff000, 16'h0000});
		send('{16'h1400, 1'b1, 16'h0000, 24'd1, 24'd0, 16'h0400});
		send('{16'hffff, 1'b0, 16'h1234, 24'hffffff, 24'd0, 16'hffff});
		send('{16'h0800, 1'b1, 16'hf000, 24'd100, 24'd10, 16'h0100});
		idle_input();
		drain();
		// directed: post path, zero everything
		for (int i = 0; i < 8; i++) write_reg(rild_pkg::reg_idx_t'(i), 16'h0000);
		send('{16'h1000, 1'b1, 16'h0000, 24'd1, 24'd0, 16'h0000});
		send('{16'h8000, 1'b0, 16'h0000, 24'd0, 24'd0, 16'h8000});
		idle_input();
		drain();
		write_reg(rild_pkg::REG_CRACKLE_AMP, 16'hffff);
		write_reg(rild_pkg::REG_CRACKLE_RATE, 16'h8000);
		send('{16'h0000, 1'b1, 16'h8000, 24'd1, 24'd0, 16'h8000});
		send('{16'h1000, 1'b1, 16'h0000, 24'd1, 24'd0, 16'h0000});
		idle_input();
		drain();
		for (int ph = 0; ph < 11; ph++) begin
			if (ph == 10) quiet = 1;
			random_regs();
			for (int n = 0; n < 100; n++) send(rand_sample());
			idle_input();
			drain();
		end
		if (board.mismatches == 0 && board.pending.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
